### src/pnc16_pkg.sv
// pnc16_pkg: shared types and constants of the nearest palette color matcher
// palette table, alpha scaling constants and distance widths; no dependencies
`default_nettype none

package pnc16_pkg;

  // palette geometry
  localparam int unsigned NumEntries = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned ProdW      = 2 * ChanW;
  // three channels of up to 255 each sum to at most 765
  localparam int unsigned DistW      = 10;
  localparam int unsigned NumGroups  = 4;
  localparam int unsigned GroupSize  = NumEntries / NumGroups;
  localparam int unsigned GrpW       = 2;
  localparam int unsigned SubW       = 2;

  // floor(p / 255) == (p * 0x8081) >> 23 for every 16-bit p
  localparam logic [ProdW-1:0] Recip255   = 16'h8081;
  localparam int unsigned      RecipShift = 23;
  localparam int unsigned      RecipW     = 2 * ProdW;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [ProdW-1:0] prod_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  idx_t;

  // console palette, entry thirteen is magenta
  localparam chan_t PalR [NumEntries] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'hc0,
    8'h80, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff
  };
  localparam chan_t PalG [NumEntries] = '{
    8'h00, 8'h00, 8'h80, 8'h80, 8'h00, 8'h00, 8'h80, 8'hc0,
    8'h80, 8'h00, 8'he6, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff
  };
  localparam chan_t PalB [NumEntries] = '{
    8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'hc0,
    8'h80, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff
  };

  // absolute difference of two channel values
  function automatic chan_t abs_diff(input chan_t x, input chan_t y);
    abs_diff = (x >= y) ? (x - y) : (y - x);
  endfunction

endpackage

`default_nettype wire

### src/palette_nearest_color_16_unit.sv
// palette_nearest_color_16_unit: premultiplies an rgba beat by alpha and returns the
// index of the nearest of 16 console colors (l1 distance); uses pnc16_pkg
//
// One pixel beat enters per clock while the output does not stall; its index goes
// through the five register stages: channel times alpha, divide by 255 through a
// reciprocal multiply, sixteen l1 distances, minimum within four groups of four,
// minimum over the groups. The lowest index wins a tie. Each stage holds its beat
// while the next one is full and stalled, so back-pressure on the output stops the
// pipe without losing or repeating a beat; the block keeps no state between pixels.
`default_nettype none

module palette_nearest_color_16_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // palette_index[3:0], zero[7:4]
);

  localparam int unsigned NumStages = 5;

  // stage valid bits and per-stage load enables
  logic [NumStages:1]   vld_q;
  logic [NumStages+1:1] en;

  assign en[NumStages+1] = m_axis_tready;
  for (genvar k = 1; k <= NumStages; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld_q[NumStages];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 1: channel times alpha
  pnc16_pkg::chan_t red, green, blue, alpha;
  pnc16_pkg::prod_t prod_r_q, prod_g_q, prod_b_q;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];
  assign alpha = s_axis_tdata[31:24];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_r_q <= pnc16_pkg::ProdW'(red) * pnc16_pkg::ProdW'(alpha);
      prod_g_q <= pnc16_pkg::ProdW'(green) * pnc16_pkg::ProdW'(alpha);
      prod_b_q <= pnc16_pkg::ProdW'(blue) * pnc16_pkg::ProdW'(alpha);
    end
  end

  // stage 2: divide by 255 through the reciprocal
  logic [pnc16_pkg::RecipW-1:0] rec_r, rec_g, rec_b;
  pnc16_pkg::chan_t              q_r_q, q_g_q, q_b_q;

  assign rec_r = pnc16_pkg::RecipW'(prod_r_q) * pnc16_pkg::RecipW'(pnc16_pkg::Recip255);
  assign rec_g = pnc16_pkg::RecipW'(prod_g_q) * pnc16_pkg::RecipW'(pnc16_pkg::Recip255);
  assign rec_b = pnc16_pkg::RecipW'(prod_b_q) * pnc16_pkg::RecipW'(pnc16_pkg::Recip255);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      q_r_q <= rec_r[pnc16_pkg::RecipShift +: pnc16_pkg::ChanW];
      q_g_q <= rec_g[pnc16_pkg::RecipShift +: pnc16_pkg::ChanW];
      q_b_q <= rec_b[pnc16_pkg::RecipShift +: pnc16_pkg::ChanW];
    end
  end

  // stage 3: l1 distance to every palette entry
  pnc16_pkg::dist_t dist_d [pnc16_pkg::NumEntries];
  pnc16_pkg::dist_t dist_q [pnc16_pkg::NumEntries];

  always_comb begin
    for (int i = 0; i < pnc16_pkg::NumEntries; i++) begin
      dist_d[i] = pnc16_pkg::DistW'(pnc16_pkg::abs_diff(q_r_q, pnc16_pkg::PalR[i]))
                + pnc16_pkg::DistW'(pnc16_pkg::abs_diff(q_g_q, pnc16_pkg::PalG[i]))
                + pnc16_pkg::DistW'(pnc16_pkg::abs_diff(q_b_q, pnc16_pkg::PalB[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dist_q <= dist_d;
    end
  end

  // stage 4: minimum inside each group of four, lowest index on tie
  pnc16_pkg::dist_t               grp_dist_d [pnc16_pkg::NumGroups];
  pnc16_pkg::dist_t               grp_dist_q [pnc16_pkg::NumGroups];
  logic [pnc16_pkg::SubW-1:0]     grp_sub_d  [pnc16_pkg::NumGroups];
  logic [pnc16_pkg::SubW-1:0]     grp_sub_q  [pnc16_pkg::NumGroups];

  always_comb begin
    for (int g = 0; g < pnc16_pkg::NumGroups; g++) begin
      grp_dist_d[g] = dist_q[g*pnc16_pkg::GroupSize];
      grp_sub_d[g]  = '0;
      for (int s = 1; s < pnc16_pkg::GroupSize; s++) begin
        if (dist_q[g*pnc16_pkg::GroupSize+s] < grp_dist_d[g]) begin
          grp_dist_d[g] = dist_q[g*pnc16_pkg::GroupSize+s];
          grp_sub_d[g]  = pnc16_pkg::SubW'(s);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      grp_dist_q <= grp_dist_d;
      grp_sub_q  <= grp_sub_d;
    end
  end

  // stage 5: minimum over the groups, lowest group on tie
  pnc16_pkg::dist_t          best_dist;
  pnc16_pkg::idx_t           best_idx;
  pnc16_pkg::idx_t           idx_q;

  always_comb begin
    best_dist = grp_dist_q[0];
    best_idx  = {pnc16_pkg::GrpW'(0), grp_sub_q[0]};
    for (int g = 1; g < pnc16_pkg::NumGroups; g++) begin
      if (grp_dist_q[g] < best_dist) begin
        best_dist = grp_dist_q[g];
        best_idx  = {pnc16_pkg::GrpW'(g), grp_sub_q[g]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      idx_q <= best_idx;
    end
  end

  assign m_axis_tdata = {4'b0000, idx_q};

  // a full stage that cannot move keeps its beat
  a_stall_keeps_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !en[4] |=> vld_q[3])
    else $error("stage 3 lost a stalled beat");

  // a group minimum never exceeds the group's first distance
  a_group_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && en[4] |=>
      (grp_dist_q[0] <= $past(dist_q[0])) && (grp_dist_q[1] <= $past(dist_q[4])) &&
      (grp_dist_q[2] <= $past(dist_q[8])) && (grp_dist_q[3] <= $past(dist_q[12])))
    else $error("group minimum above its first entry");

  // a black pixel after scaling sits at distance zero from entry zero
  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && en[3] && q_r_q == '0 && q_g_q == '0 && q_b_q == '0 |=> dist_q[0] == '0)
    else $error("black pixel not at distance zero from entry zero");

endmodule

`default_nettype wire
